// ===== hdl/dfs_pkg.sv =====
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int unsigned DFS_QUEUE_DEPTH = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEP_CHAR_0    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEP_CHAR_1    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEP_CHAR_2    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEP_CHAR_3    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FIELDS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FIELD_LEN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LINE_LEN  = 3'd6;

  localparam logic [7:0]  SEP_CHAR_RESET      = 8'd9;
  localparam logic [15:0] MAX_FIELDS_RESET    = 16'd0;
  localparam logic [11:0] MAX_FIELD_LEN_RESET = 12'd4095;
  localparam logic [15:0] MAX_LINE_LEN_RESET  = 16'd65535;
  localparam logic [15:0] FIELD_COUNT_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TOKEN_BYTE,
    KIND_FIELD_END,
    KIND_LINE_END
  } result_kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   token_byte;
    logic [15:0]  field_index;
    logic [11:0]  byte_position;
    logic         last_of_run;
  } out_item_t;

  // Work produced by the front for one input item: an optional field-end
  // result followed by an optional token-byte or line-end result.
  typedef struct packed {
    logic        has_close;
    logic [15:0] close_index;
    logic [11:0] close_len;
    logic        has_main;
    out_item_t   main;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  sep_char_0;
    logic [7:0]  sep_char_1;
    logic [7:0]  sep_char_2;
    logic [7:0]  sep_char_3;
    logic [15:0] max_fields;
    logic [11:0] max_field_len;
    logic [15:0] max_line_len;
  } cfg_t;

endpackage

// ===== hdl/dfs_front.sv =====
`timescale 1ns / 1ps

module dfs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [dfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          accept,
  input  dfs_pkg::in_item_t             item,
  output logic                          cmd_wr,
  output dfs_pkg::cmd_t                 cmd
);
  import dfs_pkg::*;

  cfg_t        cfg;
  logic        in_token;
  logic [15:0] field_count;
  logic [11:0] field_pos;
  logic [15:0] line_pos;

  logic        in_token_next;
  logic [15:0] field_count_next;
  logic [11:0] field_pos_next;
  logic [15:0] line_pos_next;

  logic        is_sep;
  logic        blocked;
  logic [15:0] count_inc;
  logic [11:0] start_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sep_char_0    <= SEP_CHAR_RESET;
      cfg.sep_char_1    <= SEP_CHAR_RESET;
      cfg.sep_char_2    <= SEP_CHAR_RESET;
      cfg.sep_char_3    <= SEP_CHAR_RESET;
      cfg.max_fields    <= MAX_FIELDS_RESET;
      cfg.max_field_len <= MAX_FIELD_LEN_RESET;
      cfg.max_line_len  <= MAX_LINE_LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEP_CHAR_0:    cfg.sep_char_0    <= cfg_data[7:0];
        CFG_SEP_CHAR_1:    cfg.sep_char_1    <= cfg_data[7:0];
        CFG_SEP_CHAR_2:    cfg.sep_char_2    <= cfg_data[7:0];
        CFG_SEP_CHAR_3:    cfg.sep_char_3    <= cfg_data[7:0];
        CFG_MAX_FIELDS:    cfg.max_fields    <= cfg_data;
        CFG_MAX_FIELD_LEN: cfg.max_field_len <= cfg_data[11:0];
        CFG_MAX_LINE_LEN:  cfg.max_line_len  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token    <= 1'b0;
      field_count <= '0;
      field_pos   <= '0;
      line_pos    <= '0;
    end else if (accept) begin
      in_token    <= in_token_next;
      field_count <= field_count_next;
      field_pos   <= field_pos_next;
      line_pos    <= line_pos_next;
    end
  end

  always_comb begin
    is_sep = (item.char_in == cfg.sep_char_0) || (item.char_in == cfg.sep_char_1) ||
             (item.char_in == cfg.sep_char_2) || (item.char_in == cfg.sep_char_3);
    blocked = (line_pos >= cfg.max_line_len) ||
              ((cfg.max_fields != '0) && (field_count >= cfg.max_fields));
    count_inc = (field_count == FIELD_COUNT_MAX) ? field_count : field_count + 16'd1;
    start_pos = in_token ? field_pos : '0;

    in_token_next    = in_token;
    field_count_next = field_count;
    field_pos_next   = field_pos;
    line_pos_next    = line_pos;

    cmd                    = '0;
    cmd.close_index        = field_count;
    cmd.close_len          = field_pos;
    cmd.main.field_index   = field_count;

    if (item.line_end) begin
      cmd.has_close          = in_token;
      cmd.has_main           = 1'b1;
      cmd.main.result_kind   = KIND_LINE_END;
      cmd.main.field_index   = in_token ? count_inc : field_count;
      cmd.main.last_of_run   = 1'b1;
      in_token_next    = 1'b0;
      field_count_next = '0;
      field_pos_next   = '0;
      line_pos_next    = '0;
    end else if (!blocked) begin
      line_pos_next = line_pos + 16'd1;
      if (is_sep) begin
        if (in_token) begin
          cmd.has_close    = 1'b1;
          in_token_next    = 1'b0;
          field_pos_next   = '0;
          field_count_next = count_inc;
        end
      end else begin
        in_token_next  = 1'b1;
        field_pos_next = start_pos;
        if (start_pos < cfg.max_field_len) begin
          cmd.has_main           = 1'b1;
          cmd.main.result_kind   = KIND_TOKEN_BYTE;
          cmd.main.token_byte    = item.char_in;
          cmd.main.byte_position = start_pos;
          field_pos_next         = start_pos + 12'd1;
        end
      end
    end

    cmd_wr = accept && (cmd.has_close || cmd.has_main);
  end

endmodule

// ===== hdl/dfs_queue.sv =====
`timescale 1ns / 1ps

module dfs_queue #(
  parameter int unsigned DEPTH = dfs_pkg::DFS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dfs_pkg::cmd_t wr_data,
  input  logic          rd,
  output dfs_pkg::cmd_t rd_data,
  output logic          full,
  output logic          not_empty
);
  import dfs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data   = mem[rd_ptr];
  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count exceeds depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) full && !rd |-> !wr)
    else $error("write into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) rd |-> not_empty)
    else $error("read from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      wr && !rd |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a lone write");

endmodule

// ===== hdl/dfs_back.sv =====
`timescale 1ns / 1ps

module dfs_back (
  input  logic               clk,
  input  logic               rst,
  input  dfs_pkg::cmd_t      q_data,
  input  logic               q_not_empty,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output dfs_pkg::out_item_t result
);
  import dfs_pkg::*;

  cmd_t cur;
  logic cur_valid;
  logic split;
  logic advance;

  // A command with both a field end and a second result takes two pops;
  // the first one only retires the field end.
  assign split   = cur.has_close && cur.has_main;
  assign advance = !cur_valid || (pop && !split);
  assign q_rd    = advance && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      cur_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur <= q_data;
    end else if (pop && cur_valid) begin
      cur.has_close <= 1'b0;
    end
  end

  always_comb begin
    if (cur.has_close) begin
      result               = '0;
      result.result_kind   = KIND_FIELD_END;
      result.field_index   = cur.close_index;
      result.byte_position = cur.close_len;
    end else begin
      result = cur.main;
    end
  end

  assign empty = !cur_valid;

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (result.last_of_run == (result.result_kind == KIND_LINE_END)))
    else $error("last_of_run does not match a line end");
  a_split_holds: assert property (@(posedge clk) disable iff (rst)
      pop && !empty && split |=> !empty && !cur.has_close)
    else $error("second result of a split transaction lost");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
      !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before it was popped");

endmodule

// ===== hdl/delimiter_field_splitter.sv =====
// An accepted input transaction is written into the command queue and then loaded into the
// result register before its first result shows on the result side.
// Throughput: one input transaction per cycle while the queue is not full; results leave at
// one per cycle while pop is held, so an item that makes a field end plus a second result
// takes two pops. A command queue (four entries by default) sits between the classifier
// and the result stage. Reset (rst, synchronous) restores the separator and limit registers
// to their defaults and clears the line state and the queue.
`timescale 1ns / 1ps

module delimiter_field_splitter #(
  parameter int unsigned QUEUE_DEPTH = dfs_pkg::DFS_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  dfs_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output dfs_pkg::out_item_t              result
);
  import dfs_pkg::*;

  logic accept;
  logic cmd_wr;
  cmd_t cmd;
  cmd_t q_data;
  logic q_rd;
  logic q_full;
  logic q_not_empty;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  dfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd)
  );

  dfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (cmd_wr),
    .wr_data   (cmd),
    .rd        (q_rd),
    .rd_data   (q_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  dfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_not_empty (q_not_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .result      (result)
  );

endmodule

// ===== tb/sv/tb_delimiter_field_splitter.sv =====
`timescale 1ns / 1ps

module tb_delimiter_field_splitter;
  import dfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STALL_CYCLES   = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 155;
  localparam int RANDOM_PHASES  = 10;
  localparam int STALL_PHASE    = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              result;

  delimiter_field_splitter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always #5 clk = ~clk;

  // Shadow of the separator and limit registers, and of the line state.
  cfg_t        split_cfg = '{
    sep_char_0: SEP_CHAR_RESET, sep_char_1: SEP_CHAR_RESET,
    sep_char_2: SEP_CHAR_RESET, sep_char_3: SEP_CHAR_RESET,
    max_fields: MAX_FIELDS_RESET, max_field_len: MAX_FIELD_LEN_RESET,
    max_line_len: MAX_LINE_LEN_RESET
  };
  logic        tok_open = 1'b0;
  logic [15:0] fields_seen = '0;
  logic [11:0] tok_len = '0;
  logic [15:0] line_len = '0;

  in_item_t  pending_bytes[$];
  out_item_t expected_pieces[$];

  int error_count = 0;
  bit in_taken = 0;
  bit res_taken = 0;
  int push_wait = 0;
  int pop_wait = 0;
  bit push_burst = 0;
  bit pop_burst = 0;
  bit stall_request = 0;
  bit stall_done = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic bit is_separator(logic [7:0] b);
    return b == split_cfg.sep_char_0 || b == split_cfg.sep_char_1 ||
           b == split_cfg.sep_char_2 || b == split_cfg.sep_char_3;
  endfunction

  function automatic void close_token();
    out_item_t r;
    r = '{result_kind: KIND_FIELD_END, token_byte: 8'd0, field_index: fields_seen,
          byte_position: tok_len, last_of_run: 1'b0};
    expected_pieces.push_back(r);
    if (fields_seen != FIELD_COUNT_MAX) fields_seen++;
    tok_open = 1'b0;
    tok_len = '0;
  endfunction

  // Works out the results that one accepted byte or terminator produces.
  function automatic void split_item(in_item_t it);
    out_item_t r;
    if (it.line_end) begin
      if (tok_open) close_token();
      r = '{result_kind: KIND_LINE_END, token_byte: 8'd0, field_index: fields_seen,
            byte_position: 12'd0, last_of_run: 1'b1};
      expected_pieces.push_back(r);
      tok_open = 1'b0;
      fields_seen = '0;
      tok_len = '0;
      line_len = '0;
      return;
    end
    if (line_len >= split_cfg.max_line_len) return;
    if (split_cfg.max_fields != 0 && fields_seen >= split_cfg.max_fields) return;
    line_len++;
    if (is_separator(it.char_in)) begin
      if (tok_open) close_token();
      return;
    end
    if (!tok_open) begin
      tok_open = 1'b1;
      tok_len = '0;
    end
    if (tok_len < split_cfg.max_field_len) begin
      r = '{result_kind: KIND_TOKEN_BYTE, token_byte: it.char_in, field_index: fields_seen,
            byte_position: tok_len, last_of_run: 1'b0};
      expected_pieces.push_back(r);
      tok_len++;
    end
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (!rst && push && !full) begin
      split_item(item);
      void'(pending_bytes.pop_front());
      in_taken = 1;
    end
    if (!rst && pop && !empty) begin
      res_taken = 1;
      if (expected_pieces.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d byte %0h index %0d pos %0d",
                               result.result_kind, result.token_byte, result.field_index,
                               result.byte_position));
      end else begin
        want = expected_pieces.pop_front();
        if (result.result_kind !== want.result_kind)
          report_error($sformatf("result_kind got %0d expected %0d",
                                 result.result_kind, want.result_kind));
        if (result.token_byte !== want.token_byte)
          report_error($sformatf("token_byte got %0h expected %0h",
                                 result.token_byte, want.token_byte));
        if (result.field_index !== want.field_index)
          report_error($sformatf("field_index got %0d expected %0d",
                                 result.field_index, want.field_index));
        if (result.byte_position !== want.byte_position)
          report_error($sformatf("byte_position got %0d expected %0d",
                                 result.byte_position, want.byte_position));
        if (result.last_of_run !== want.last_of_run)
          report_error($sformatf("last_of_run got %0b expected %0b",
                                 result.last_of_run, want.last_of_run));
      end
    end
  end

  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 0;
      push_wait = draw_gap(push_burst);
    end
    if (rst) begin
      push <= 1'b0;
    end else if (push_wait > 0) begin
      push_wait--;
      push <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      push <= 1'b1;
      item <= pending_bytes[0];
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (res_taken) begin
      res_taken = 0;
      pop_wait = draw_gap(pop_burst);
    end
    if (rst || stall_left > 0) begin
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop_wait--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Long hold-off on the result side so that the block backs up into its input.
  always @(posedge clk) begin
    if (stall_request && !stall_done) begin
      stall_done = 1;
      stall_left = STALL_CYCLES;
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEP_CHAR_0:    split_cfg.sep_char_0 = data[7:0];
      CFG_SEP_CHAR_1:    split_cfg.sep_char_1 = data[7:0];
      CFG_SEP_CHAR_2:    split_cfg.sep_char_2 = data[7:0];
      CFG_SEP_CHAR_3:    split_cfg.sep_char_3 = data[7:0];
      CFG_MAX_FIELDS:    split_cfg.max_fields = data;
      CFG_MAX_FIELD_LEN: split_cfg.max_field_len = data[11:0];
      CFG_MAX_LINE_LEN:  split_cfg.max_line_len = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    pending_bytes.push_back('{char_in: b, line_end: 1'b0});
  endtask

  task automatic add_term(input logic [7:0] b);
    pending_bytes.push_back('{char_in: b, line_end: 1'b1});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(32, 126));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_separator(b));
    return b;
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 3))
      0: return split_cfg.sep_char_0;
      1: return split_cfg.sep_char_1;
      2: return split_cfg.sep_char_2;
      default: return split_cfg.sep_char_3;
    endcase
  endfunction

  task automatic configure_phase(input int p);
    logic [7:0]  s [4];
    logic [15:0] mf;
    logic [11:0] fl;
    logic [15:0] ll;
    foreach (s[i]) s[i] = pick_sep();
    // Single-separator mode now and then.
    if ($urandom_range(0, 3) == 0) begin
      s[1] = s[0];
      s[2] = s[0];
      s[3] = s[0];
    end
    case ($urandom_range(0, 3))
      0: mf = 16'd0;
      1: mf = 16'hFFFF;
      2: mf = 16'($urandom_range(1, 6));
      default: mf = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: fl = 12'd1;
      1: fl = 12'd4095;
      2: fl = 12'($urandom_range(2, 8));
      default: fl = 12'($urandom_range(1, 4095));
    endcase
    case ($urandom_range(0, 3))
      0: ll = 16'd1;
      1: ll = 16'hFFFF;
      2: ll = 16'($urandom_range(4, 40));
      default: ll = 16'($urandom_range(1, 65535));
    endcase
    if (p == 0) begin
      s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      mf = 16'hFFFF;
      fl = 12'd4095;
      ll = 16'hFFFF;
    end else if (p == 1) begin
      s = '{8'h00, 8'h00, 8'h00, 8'h00};
      mf = 16'd0;
      fl = 12'd1;
      ll = 16'd1;
    end
    write_reg(CFG_SEP_CHAR_0, {8'd0, s[0]});
    write_reg(CFG_SEP_CHAR_1, {8'd0, s[1]});
    write_reg(CFG_SEP_CHAR_2, {8'd0, s[2]});
    write_reg(CFG_SEP_CHAR_3, {8'd0, s[3]});
    write_reg(CFG_MAX_FIELDS, mf);
    write_reg(CFG_MAX_FIELD_LEN, {4'd0, fl});
    write_reg(CFG_MAX_LINE_LEN, ll);
  endtask

  // Mostly well-formed lines; about one in eight is raw noise with stray terminators.
  task automatic add_line();
    int nf;
    int tl;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 9) == 0) add_term(8'($urandom_range(0, 255)));
        else add_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    repeat ($urandom_range(0, 2)) add_byte(sep_char());
    nf = $urandom_range(0, 6);
    for (int f = 0; f < nf; f++) begin
      tl = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 6);
      repeat (tl) add_byte(token_char());
      if (f < nf - 1) repeat ($urandom_range(1, 3)) add_byte(sep_char());
      else repeat ($urandom_range(0, 2)) add_byte(sep_char());
    end
    add_term(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default separator (tab): leading and repeated separators, extreme bytes,
    // a terminator right after a token and one on an empty line.
    add_byte(SEP_CHAR_RESET);
    add_byte(SEP_CHAR_RESET);
    add_text("AB");
    add_byte(SEP_CHAR_RESET);
    add_byte(SEP_CHAR_RESET);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_term(8'hFF);
    add_term(8'h00);
    wait_drained();

    // Tight limits: field too long and field limit reached in one line.
    write_reg(CFG_SEP_CHAR_0, 16'h0000);
    write_reg(CFG_SEP_CHAR_1, 16'h00FF);
    write_reg(CFG_SEP_CHAR_2, 16'(","));
    write_reg(CFG_SEP_CHAR_3, 16'(" "));
    write_reg(CFG_MAX_FIELDS, 16'd2);
    write_reg(CFG_MAX_FIELD_LEN, 16'd1);
    write_reg(CFG_MAX_LINE_LEN, 16'd7);
    add_text("ab,cd,ef");
    add_term(8'h00);
    add_text("x");
    add_byte(8'hFF);
    add_term(8'hFF);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure_phase(p);
      if (p == STALL_PHASE) stall_request = 1;
      while (pending_bytes.size() < PHASE_ITEMS) add_line();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
